[rtl/hsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants of the static Huffman stream decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

    // default sizes
    localparam int MAX_LEAVES_DEF        = 256;
    localparam int LENGTH_FIELD_BITS_DEF = 12;

    // result status codes
    localparam logic [2:0] ST_SYMBOL    = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_LEFTOVER  = 3'd2;
    localparam logic [2:0] ST_BAD_CODE  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    // stream parse phase
    typedef enum logic [1:0] {
        PH_COUNT,
        PH_LENGTH,
        PH_TREE,
        PH_CODE
    } phase_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_POP,
        S_CODE,
        S_END,
        S_FLUSH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic pop_done;
        logic code_done;
        logic end_check;
        logic flush;
    } hsd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic stop;
        logic pop_wait;
        logic code_wait;
        logic can_emit;
    } hsd_stat_t;

endpackage : hsd_pkg
`default_nettype wire

[rtl/hsd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_ctrl
// Sequencer: takes one byte, walks its bits and closes the byte.
// ----------------------------------------------------------------------------
module hsd_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    output hsd_pkg::hsd_cmd_t cmd,
    input  hsd_pkg::hsd_stat_t stat
);
    import hsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (stat.stop)
                begin
                    state_next = S_END;
                end
                else if (stat.can_emit)
                begin
                    if (stat.pop_wait)
                    begin
                        state_next = S_POP;
                    end
                    else if (stat.code_wait)
                    begin
                        state_next = S_CODE;
                    end
                end
            end
            S_POP, S_CODE:
            begin
                if (stat.can_emit)
                begin
                    state_next = S_BIT;
                end
            end
            S_END:
            begin
                if (stat.can_emit)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (stat.can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_BIT:
            begin
                cmd.step = !stat.stop && stat.can_emit;
            end
            S_POP:
            begin
                cmd.pop_done = stat.can_emit;
            end
            S_CODE:
            begin
                cmd.code_done = stat.can_emit;
            end
            S_END:
            begin
                cmd.end_check = stat.can_emit;
            end
            S_FLUSH:
            begin
                cmd.flush = stat.can_emit;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule : hsd_ctrl
`default_nettype wire

[rtl/hsd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_datapath
// Header and tree registers, node table, node stack, result hold and output.
// ----------------------------------------------------------------------------
module hsd_datapath #(
    parameter int MAX_LEAVES        = hsd_pkg::MAX_LEAVES_DEF,
    parameter int LENGTH_FIELD_BITS = hsd_pkg::LENGTH_FIELD_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  hsd_pkg::hsd_cmd_t  cmd,
    output hsd_pkg::hsd_stat_t stat,
    input  wire  [7:0]         byte_in,
    input  wire                last_byte,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [7:0]         symbol,
    output logic [2:0]         status,
    output logic               last_of_run
);
    import hsd_pkg::*;

    localparam int NIW  = $clog2(2 * MAX_LEAVES);
    localparam int SIW  = $clog2(MAX_LEAVES);
    localparam int DW   = $clog2(MAX_LEAVES + 1);
    localparam int HBW  = $clog2(LENGTH_FIELD_BITS + 1);
    localparam int LFB  = LENGTH_FIELD_BITS;
    localparam int LW   = (NIW > 8) ? NIW : 8;
    localparam int EW   = 1 + LW + NIW;
    localparam logic [NIW-1:0] NODE_LIMIT = NIW'(2 * MAX_LEAVES - 1);
    localparam logic [DW-1:0]  STACK_CAP  = DW'(MAX_LEAVES);

    // control registers
    phase_t         phase_reg, phase_next;
    logic [HBW-1:0] hb_reg, hb_next;
    logic [3:0]     fv_reg, fv_next;
    logic [LFB-1:0] tl_reg, tl_next;
    logic [LFB:0]   tbd_reg, tbd_next;
    logic [7:0]     ls_reg, ls_next;
    logic [3:0]     lb_reg, lb_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [NIW-1:0] nu_reg, nu_next;
    logic           err_reg, err_next;
    logic [3:0]     idx_reg, idx_next;
    logic           hold_valid_reg, hold_valid_next;
    logic           out_valid_reg, out_valid_next;

    // payload registers
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic [NIW-1:0] top_reg, top_next;
    logic [EW-1:0]  walk_reg, walk_next;
    logic [EW-1:0]  root_reg, root_next;
    logic [7:0]     hold_sym_reg, hold_sym_next;
    logic [2:0]     hold_st_reg, hold_st_next;
    logic [7:0]     out_sym_reg, out_sym_next;
    logic [2:0]     out_st_reg, out_st_next;
    logic           out_last_reg, out_last_next;

    // memories
    logic [EW-1:0]  tbl_mem [2 * MAX_LEAVES];
    logic [EW-1:0]  tbl_rd;
    logic           tbl_we, tbl_re;
    logic [NIW-1:0] tbl_waddr, tbl_raddr;
    logic [EW-1:0]  tbl_wdata;
    logic [NIW-1:0] stk_mem [MAX_LEAVES];
    logic [NIW-1:0] stk_rd;
    logic           stk_we, stk_re;
    logic [SIW-1:0] stk_waddr, stk_raddr;

    logic           cur_bit;
    logic           out_free;
    logic           can_emit;

    assign cur_bit  = byte_reg[~idx_reg[2:0]];
    assign out_free = !out_valid_reg || !out_stall;
    assign can_emit = !hold_valid_reg || out_free;

    // status toward the controller
    always_comb
    begin
        stat.stop      = err_reg || idx_reg[3] ||
                         (last_reg && (phase_reg != PH_COUNT) && (idx_reg >= fv_reg));
        stat.pop_wait  = (phase_reg == PH_TREE) && (lb_reg == 4'd0) && !cur_bit &&
                         (depth_reg >= DW'(2));
        stat.code_wait = (phase_reg == PH_CODE) && !walk_reg[EW-1];
        stat.can_emit  = can_emit;
    end

    // bit processing, result hold and output register
    always_comb
    begin
        logic           emit_en;
        logic [2:0]     emit_st;
        logic [7:0]     emit_sym;
        logic [HBW-1:0] hb_inc;
        logic [2:0]     fv_base;
        logic [2:0]     fv3;
        logic [3:0]     fv_fin;
        logic [LFB-1:0] tl_new;
        logic [LFB:0]   tbd_inc;
        logic [7:0]     ls_new;
        logic [EW-1:0]  entry;
        logic [NIW-1:0] child;

        phase_next      = phase_reg;
        hb_next         = hb_reg;
        fv_next         = fv_reg;
        tl_next         = tl_reg;
        tbd_next        = tbd_reg;
        ls_next         = ls_reg;
        lb_next         = lb_reg;
        depth_next      = depth_reg;
        nu_next         = nu_reg;
        err_next        = err_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg && !out_free;
        byte_next       = byte_reg;
        last_next       = last_reg;
        top_next        = top_reg;
        walk_next       = walk_reg;
        root_next       = root_reg;
        hold_sym_next   = hold_sym_reg;
        hold_st_next    = hold_st_reg;
        out_sym_next    = out_sym_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;

        emit_en   = 1'b0;
        emit_st   = ST_SYMBOL;
        emit_sym  = 8'd0;
        hb_inc    = hb_reg + HBW'(1);
        fv_base   = (hb_reg == '0) ? 3'd0 : fv_reg[2:0];
        fv3       = {fv_base[1:0], cur_bit};
        fv_fin    = (fv3 == 3'd0) ? 4'd8 : {1'b0, fv3};
        tl_new    = tl_reg | (LFB'(cur_bit) << hb_reg);
        tbd_inc   = tbd_reg + (LFB+1)'(1);
        ls_new    = {ls_reg[6:0], cur_bit};
        entry     = '0;
        child     = cur_bit ? walk_reg[NIW-1:0] : walk_reg[NIW +: NIW];

        tbl_we    = 1'b0;
        tbl_re    = 1'b0;
        tbl_waddr = nu_reg;
        tbl_raddr = child;
        tbl_wdata = '0;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = SIW'(depth_reg - DW'(1));
        stk_raddr = SIW'(depth_reg - DW'(2));

        // take a new byte
        if (cmd.load)
        begin
            byte_next = byte_in;
            last_next = last_byte;
            idx_next  = 4'd0;
        end

        // one bit of the byte
        if (cmd.step)
        begin
            idx_next = idx_reg + 4'd1;
            case (phase_reg)
                PH_COUNT:
                begin
                    if (hb_inc >= HBW'(3))
                    begin
                        fv_next    = fv_fin;
                        hb_next    = '0;
                        tl_next    = '0;
                        phase_next = PH_LENGTH;
                        if (last_reg && ((idx_reg + 4'd1) > fv_fin))
                        begin
                            emit_en = 1'b1;
                            emit_st = ST_TRUNCATED;
                        end
                    end
                    else
                    begin
                        fv_next = {1'b0, fv3};
                        hb_next = hb_inc;
                    end
                end
                PH_LENGTH:
                begin
                    tl_next = tl_new;
                    if (hb_inc >= HBW'(LFB))
                    begin
                        hb_next    = '0;
                        tbd_next   = '0;
                        lb_next    = 4'd0;
                        depth_next = '0;
                        nu_next    = '0;
                        phase_next = PH_TREE;
                        if (tl_new == '0)
                        begin
                            emit_en = 1'b1;
                            emit_st = ST_LEFTOVER;
                        end
                    end
                    else
                    begin
                        hb_next = hb_inc;
                    end
                end
                PH_TREE:
                begin
                    tbd_next = tbd_inc;
                    if (lb_reg != 4'd0)
                    begin
                        ls_next = ls_new;
                        lb_next = lb_reg - 4'd1;
                        if (lb_reg == 4'd1)
                        begin
                            if ((nu_reg >= NODE_LIMIT) || (depth_reg >= STACK_CAP))
                            begin
                                emit_en = 1'b1;
                                emit_st = ST_LEFTOVER;
                            end
                            else
                            begin
                                entry      = {1'b1, LW'(ls_new), NIW'(0)};
                                tbl_we     = 1'b1;
                                tbl_wdata  = entry;
                                stk_we     = (depth_reg != '0);
                                top_next   = nu_reg;
                                nu_next    = nu_reg + NIW'(1);
                                depth_next = depth_reg + DW'(1);
                                if (tbd_inc >= {1'b0, tl_reg})
                                begin
                                    if (depth_reg != '0)
                                    begin
                                        emit_en = 1'b1;
                                        emit_st = ST_LEFTOVER;
                                    end
                                    else
                                    begin
                                        phase_next = PH_CODE;
                                        walk_next  = entry;
                                        root_next  = entry;
                                    end
                                end
                            end
                        end
                    end
                    else if (cur_bit)
                    begin
                        lb_next = 4'd8;
                        ls_next = 8'd0;
                    end
                    else if (depth_reg < DW'(2))
                    begin
                        emit_en = 1'b1;
                        emit_st = ST_UNDERFLOW;
                    end
                    else
                    begin
                        stk_re = 1'b1;
                    end
                end
                default:
                begin
                    if (walk_reg[EW-1])
                    begin
                        emit_en = 1'b1;
                        emit_st = ST_BAD_CODE;
                    end
                    else
                    begin
                        tbl_re = 1'b1;
                    end
                end
            endcase
        end

        // internal node: left child came from the stack memory
        if (cmd.pop_done)
        begin
            if (nu_reg >= NODE_LIMIT)
            begin
                depth_next = depth_reg - DW'(2);
                emit_en    = 1'b1;
                emit_st    = ST_LEFTOVER;
            end
            else
            begin
                entry      = {1'b0, LW'(stk_rd), top_reg};
                tbl_we     = 1'b1;
                tbl_wdata  = entry;
                top_next   = nu_reg;
                nu_next    = nu_reg + NIW'(1);
                depth_next = depth_reg - DW'(1);
                if (tbd_reg >= {1'b0, tl_reg})
                begin
                    if (depth_reg != DW'(2))
                    begin
                        emit_en = 1'b1;
                        emit_st = ST_LEFTOVER;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                        walk_next  = entry;
                        root_next  = entry;
                    end
                end
            end
        end

        // code walk: child entry came from the node table
        if (cmd.code_done)
        begin
            if (tbl_rd[EW-1])
            begin
                emit_en   = 1'b1;
                emit_sym  = tbl_rd[NIW +: 8];
                walk_next = root_reg;
            end
            else
            begin
                walk_next = tbl_rd;
            end
        end

        // truncated stream at the final byte
        if (cmd.end_check && last_reg && !err_reg && (phase_reg != PH_CODE))
        begin
            emit_en = 1'b1;
            emit_st = ST_TRUNCATED;
        end

        // new result goes to hold, older one moves on to the output
        if (emit_en)
        begin
            if (emit_st != ST_SYMBOL)
            begin
                err_next = 1'b1;
            end
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = hold_sym_reg;
                out_st_next    = hold_st_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_sym_next   = emit_sym;
            hold_st_next    = emit_st;
        end

        // close the byte: last held result ends the run; a final byte resets the header state
        if (cmd.flush)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_sym_next    = hold_sym_reg;
                out_st_next     = hold_st_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end
            if (last_reg)
            begin
                phase_next = PH_COUNT;
                hb_next    = '0;
                fv_next    = 4'd8;
                tl_next    = '0;
                tbd_next   = '0;
                ls_next    = 8'd0;
                lb_next    = 4'd0;
                depth_next = '0;
                nu_next    = '0;
                err_next   = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_COUNT;
            hb_reg         <= '0;
            fv_reg         <= 4'd8;
            tl_reg         <= '0;
            tbd_reg        <= '0;
            ls_reg         <= 8'd0;
            lb_reg         <= 4'd0;
            depth_reg      <= '0;
            nu_reg         <= '0;
            err_reg        <= 1'b0;
            idx_reg        <= 4'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hb_reg         <= hb_next;
            fv_reg         <= fv_next;
            tl_reg         <= tl_next;
            tbd_reg        <= tbd_next;
            ls_reg         <= ls_next;
            lb_reg         <= lb_next;
            depth_reg      <= depth_next;
            nu_reg         <= nu_next;
            err_reg        <= err_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        top_reg      <= top_next;
        walk_reg     <= walk_next;
        root_reg     <= root_next;
        hold_sym_reg <= hold_sym_next;
        hold_st_reg  <= hold_st_next;
        out_sym_reg  <= out_sym_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    // node table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rd <= tbl_mem[tbl_raddr];
        end
    end

    // node stack below the top entry
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= top_reg;
        end
        if (stk_re)
        begin
            stk_rd <= stk_mem[stk_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol      = out_sym_reg;
    assign status      = out_st_reg;
    assign last_of_run = out_last_reg;

endmodule : hsd_datapath
`default_nettype wire

[rtl/huffman_stream_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_stream_decoder_top
// Static Huffman stream decoder: header, post-order tree build, code walk.
// ----------------------------------------------------------------------------
// channel | handshake            | fields
// input   | in_valid / in_stall  | byte_in[7:0], last_byte
// output  | out_valid / out_stall| symbol[7:0], status[2:0], last_of_run
//
// one full byte passes through entry, a bit step for each header, leaf or
// push bit, a bit step and then a pop or code step for each internal-node or
// code bit, then stop check, end check and close; the extra step comes from
// the registered node table / stack read.
// in_stall is high from the accept until the byte is closed.
// results leave through a hold register and an output register; a stalled
// output holds the bit walk until room frees up.
// reset clears all control state at once; no memory clearing pass.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_top #(
    parameter int MAX_LEAVES        = hsd_pkg::MAX_LEAVES_DEF,
    parameter int LENGTH_FIELD_BITS = hsd_pkg::LENGTH_FIELD_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [7:0] byte_in,
    input  wire        last_byte,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] symbol,
    output logic [2:0] status,
    output logic       last_of_run
);
    import hsd_pkg::*;

    hsd_cmd_t  cmd;
    hsd_stat_t stat;

    // sequencer
    hsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath
    hsd_datapath #(
        .MAX_LEAVES        (MAX_LEAVES),
        .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .byte_in     (byte_in),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule : huffman_stream_decoder_top
`default_nettype wire

[rtl/hsd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hsd_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_stall,
    input wire       out_valid,
    input wire       out_stall,
    input wire [7:0] symbol,
    input wire [2:0] status,
    input wire       last_of_run
);
    import hsd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(symbol) && $stable(status) &&
        $stable(last_of_run))
        else $error("stalled result changed");

    // errors carry a zero symbol
    a_err_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_SYMBOL) |-> symbol == 8'd0)
        else $error("error result with nonzero symbol");

    // status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_TRUNCATED)
        else $error("status code out of range");

    // busy right after an item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

endmodule : hsd_checker

bind huffman_stream_decoder_top hsd_checker u_hsd_checker (.*);
`default_nettype wire
